### rtl/spr_pkg.sv
// ----------------------------------------------------------------------------
// spr_pkg: shared types and constants of the sparse PageRank engine
// Opcodes, register indexes, status codes, divider request and response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package spr_pkg;

    localparam int MAX_NODES = 1024;
    localparam int MAX_EDGES = 8192;
    localparam int NODE_W    = 10;
    localparam int NCNT_W    = 11;
    localparam int EDGE_AW   = 13;
    localparam int ECNT_W    = 14;
    localparam int DIV_W     = 48;
    localparam int DVS_W     = 14;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_RUN   = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        REG_NODES = 3'd0,
        REG_DAMP  = 3'd1,
        REG_TOL   = 3'd2,
        REG_MAXIT = 3'd3,
        REG_MODE  = 3'd4
    } t_reg;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_REJECT = 2'd1,
        ST_CAP    = 2'd2
    } t_status;

    // request to the shared divider; short_div takes a 32-bit dividend
    typedef struct packed {
        logic               start;
        logic               short_div;
        logic [DIV_W-1:0]   dividend;
        logic [DVS_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_W-1:0]   quot;
    } t_div_rsp;

    function automatic logic [31:0] sat32(input logic [DIV_W-1:0] x);
        return (|x[DIV_W-1:32]) ? 32'hFFFF_FFFF : x[31:0];
    endfunction

endpackage
`default_nettype wire

### rtl/spr_in_if.sv
// ----------------------------------------------------------------------------
// spr_in_if: command channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface spr_in_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                op;
    logic [spr_pkg::NODE_W-1:0] edge_source;
    logic [spr_pkg::NODE_W-1:0] edge_target;
    logic [spr_pkg::NODE_W-1:0] read_node;

    modport source(output valid, op, edge_source, edge_target, read_node, input ready);
    modport sink(input valid, op, edge_source, edge_target, read_node, output ready);
endinterface
`default_nettype wire

### rtl/spr_out_if.sv
// ----------------------------------------------------------------------------
// spr_out_if: result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface spr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] rank_value;
    logic [15:0] iterations_done;
    logic [31:0] final_difference;

    modport source(output valid, status, rank_value, iterations_done, final_difference,
                   input ready);
    modport sink(input valid, status, rank_value, iterations_done, final_difference,
                 output ready);
endinterface
`default_nettype wire

### rtl/spr_div.sv
// ----------------------------------------------------------------------------
// spr_div: shared restoring divider
// One quotient bit per cycle; the quotient has 32 bits for a short dividend, 48 otherwise.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module spr_div (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  spr_pkg::t_div_req i_req,
    output spr_pkg::t_div_rsp o_rsp
);
    localparam int DW = spr_pkg::DIV_W;
    localparam int VW = spr_pkg::DVS_W;

    logic          r_busy;
    logic          r_done;
    logic          r_short;
    logic [5:0]    r_cnt;
    logic [DW-1:0] r_q;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_dvs;

    logic [VW:0]   rem_sh;
    logic          ge;
    logic [VW:0]   rem_nx;

    // one restoring step
    always_comb begin
        rem_sh = {r_rem, r_q[DW-1]};
        ge     = rem_sh >= {1'b0, r_dvs};
        rem_nx = ge ? rem_sh - {1'b0, r_dvs} : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_short <= i_req.short_div;
                r_q     <= i_req.short_div ? {i_req.dividend[31:0], 16'b0} : i_req.dividend;
                r_cnt   <= i_req.short_div ? 6'd31 : 6'(DW - 1);
                r_rem   <= '0;
                r_dvs   <= i_req.divisor;
            end else if (r_busy) begin
                r_q   <= {r_q[DW-2:0], ge};
                r_rem <= rem_nx[VW-1:0];
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 6'd1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_short ? {16'b0, r_q[31:0]} : r_q;
endmodule
`default_nettype wire

### rtl/sparse_pagerank_power_iteration.sv
// ----------------------------------------------------------------------------
// sparse_pagerank_power_iteration: sparse PageRank engine
// Edge store, out-degree table and rank vectors in on-chip RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Command items arrive on i_in (load edge, run, read rank, clear graph);
//   each gives exactly one result item on o_out. The user writes registers through
//   i_cfg_we / i_cfg_idx / i_cfg_data only while the block is idle; not enforced.
// Divider: the shared bit-serial divider does one division per node and step,
//   one per step for the teleport term and one per run for the start value;
//   an in-degree run does one per node when edges are stored.
// Throughput: one item at a time; a new item is taken once the previous one
//   has placed its result in the output register.
// Reset: a clearing pass zeroes all 1024 entries of the out-degree table; no
//   item is taken meanwhile. Configuration returns to its reset values.
// Stall: a result waits in the output register; the next item may already
//   be taken and is held back only when its own result is ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sparse_pagerank_power_iteration (
    input  wire               i_clk,
    input  wire               i_rst_n,
    spr_in_if.sink            i_in,
    spr_out_if.source         o_out,
    input  wire               i_cfg_we,
    input  wire [2:0]         i_cfg_idx,
    input  wire [31:0]        i_cfg_data
);
    localparam int NN = spr_pkg::MAX_NODES;
    localparam int NE = spr_pkg::MAX_EDGES;
    localparam int NW = spr_pkg::NODE_W;
    localparam int CW = spr_pkg::NCNT_W;
    localparam int AW = spr_pkg::EDGE_AW;
    localparam int EW = spr_pkg::ECNT_W;
    localparam int DW = spr_pkg::DIV_W;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_LD2, S_RD, S_PR_DIV, S_PR_FILL,
        S_A_RD, S_A_MUL, S_A_ACC, S_A_DIV,
        S_B_RD, S_B_E, S_B_ADD, S_T_DIV,
        S_C_RD, S_C_SUM, S_C_WR, S_C_END,
        S_ID_ZERO, S_ID_RD, S_ID_CALC, S_ID_DIV, S_DONE
    } t_state;

    // configuration
    logic [CW-1:0] r_node_count;
    logic [15:0]   r_damping;
    logic [31:0]   r_tol;
    logic [15:0]   r_maxit;
    logic          r_mode;

    // control and datapath
    t_state        r_state;
    logic [EW-1:0] r_idx;
    logic [EW-1:0] r_edges;
    logic          r_clr_op;
    logic [NW-1:0] r_src;
    logic [NW-1:0] r_t;
    logic [13:0]   r_od;
    logic [31:0]   r_cv;
    logic [48:0]   r_tkp;
    logic [58:0]   r_tk;
    logic [41:0]   r_dang;
    logic [43:0]   r_base;
    logic [42:0]   r_diff;
    logic [31:0]   r_nv;
    logic [31:0]   r_ov;
    logic [31:0]   r_start;
    logic [15:0]   r_iter;
    logic [15:0]   r_run_iter;
    logic [31:0]   r_run_diff;
    logic [1:0]    r_res_status;
    logic [31:0]   r_res_rank;

    // output register
    logic          r_out_valid;
    logic [1:0]    r_o_status;
    logic [31:0]   r_o_rank;
    logic [15:0]   r_o_iter;
    logic [31:0]   r_o_diff;

    // memories and registered read data
    logic [2*NW-1:0] m_edge  [NE];
    logic [13:0]     m_odeg  [NN];
    logic [31:0]     m_rank  [NN];
    logic [31:0]     m_share [NN];
    logic [32:0]     m_acc   [NN];
    logic [2*NW-1:0] r_edge_q;
    logic [13:0]     r_odeg_q;
    logic [31:0]     r_rank_q;
    logic [31:0]     r_share_q;
    logic [32:0]     r_acc_q;

    logic            edge_we;
    logic [AW-1:0]   edge_wa, edge_ra;
    logic [2*NW-1:0] edge_wd;
    logic            odeg_we;
    logic [NW-1:0]   odeg_wa, odeg_ra;
    logic [13:0]     odeg_wd;
    logic            rank_we;
    logic [NW-1:0]   rank_wa, rank_ra;
    logic [31:0]     rank_wd;
    logic            share_we;
    logic [NW-1:0]   share_wa, share_ra;
    logic            acc_we;
    logic [NW-1:0]   acc_wa, acc_ra;
    logic [32:0]     acc_wd;

    spr_pkg::t_div_req div_req;
    spr_pkg::t_div_rsp div_rsp;

    logic [CW-1:0] n_eff;
    logic [CW-1:0] n_m1;
    logic          last_node;
    logic          in_acc;
    logic          reject;
    logic [NW-1:0] e_src, e_tgt;
    logic          e_in;
    logic [33:0]   acc_sum;
    logic [47:0]   cv_full;
    logic [16:0]   omd;
    logic [47:0]   nv_sum;
    logic [31:0]   abs_d;
    logic [31:0]   diff_sat;
    logic [15:0]   it_nx;
    logic [15:0]   cap;
    logic          more;

    spr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // node count in force and common decodes
    always_comb begin
        if (r_node_count == '0)
            n_eff = CW'(1);
        else if (r_node_count > CW'(NN))
            n_eff = CW'(NN);
        else
            n_eff = r_node_count;
        n_m1      = n_eff - CW'(1);
        last_node = r_idx[CW-1:0] == n_m1;
        in_acc    = i_in.valid && (r_state == S_IDLE);
        reject    = (r_edges >= EW'(NE)) || ({1'b0, i_in.edge_source} >= n_eff)
                    || ({1'b0, i_in.edge_target} >= n_eff);
        e_src     = r_edge_q[2*NW-1:NW];
        e_tgt     = r_edge_q[NW-1:0];
        e_in      = ({1'b0, e_src} < n_eff) && ({1'b0, e_tgt} < n_eff);
        acc_sum   = {1'b0, r_acc_q} + (r_mode ? 34'd1 : {2'b0, r_share_q});
        cv_full   = 48'(r_rank_q) * 48'(r_damping);
        omd       = 17'h1_0000 - {1'b0, r_damping};
        nv_sum    = 48'(r_acc_q) + 48'(r_base);
        abs_d     = (r_nv > r_ov) ? r_nv - r_ov : r_ov - r_nv;
        diff_sat  = spr_pkg::sat32({5'b0, r_diff});
        it_nx     = r_iter + 16'd1;
        cap       = (r_maxit == 16'd0) ? 16'd1 : r_maxit;
        more      = (diff_sat > r_tol) && (it_nx < cap);
    end

    // memory port control
    always_comb begin
        edge_we  = in_acc && (i_in.op == spr_pkg::OP_LOAD) && !reject;
        edge_wa  = r_edges[AW-1:0];
        edge_wd  = {i_in.edge_source, i_in.edge_target};
        edge_ra  = r_idx[AW-1:0];

        odeg_we  = (r_state == S_CLR) || (r_state == S_LD2);
        odeg_wa  = (r_state == S_LD2) ? r_src : r_idx[NW-1:0];
        odeg_wd  = (r_state == S_LD2) ? r_odeg_q + 14'd1 : 14'd0;
        odeg_ra  = (r_state == S_IDLE) ? i_in.edge_source : r_idx[NW-1:0];

        rank_ra  = (r_state == S_IDLE) ? i_in.read_node : r_idx[NW-1:0];
        rank_wa  = r_idx[NW-1:0];
        rank_we  = 1'b0;
        rank_wd  = r_start;
        case (r_state)
            S_PR_FILL: rank_we = 1'b1;
            S_C_WR: begin
                rank_we = 1'b1;
                rank_wd = r_nv;
            end
            S_ID_CALC: begin
                rank_we = (r_edges == '0);
                rank_wd = 32'd0;
            end
            S_ID_DIV: begin
                rank_we = div_rsp.done;
                rank_wd = spr_pkg::sat32(div_rsp.quot);
            end
            default: ;
        endcase

        share_we = (r_state == S_A_DIV) && div_rsp.done && (r_od != 14'd0);
        share_wa = r_idx[NW-1:0];
        share_ra = e_src;

        acc_we   = (r_state == S_A_RD) || (r_state == S_ID_ZERO) || (r_state == S_B_ADD);
        acc_wa   = (r_state == S_B_ADD) ? r_t : r_idx[NW-1:0];
        acc_wd   = (r_state != S_B_ADD) ? 33'd0
                 : ((|acc_sum[33:32]) ? 33'h1_0000_0000 : acc_sum[32:0]);
        acc_ra   = (r_state == S_B_E) ? e_tgt : r_idx[NW-1:0];
    end

    // divider requests
    always_comb begin
        div_req           = '0;
        div_req.divisor   = 14'(n_eff);
        case (r_state)
            S_IDLE: begin
                div_req.start    = in_acc && (i_in.op == spr_pkg::OP_RUN) && !r_mode;
                div_req.dividend = DW'(64'h1_0000_0000);
            end
            S_A_ACC: begin
                div_req.start     = 1'b1;
                div_req.short_div = 1'b1;
                div_req.dividend  = DW'(r_cv);
                if (r_od != 14'd0)
                    div_req.divisor = r_od;
            end
            S_B_RD: begin
                div_req.start    = (r_idx >= r_edges) && !r_mode;
                div_req.dividend = DW'(r_tk[58:16]);
            end
            S_ID_CALC: begin
                div_req.start    = (r_edges != '0);
                div_req.dividend = {2'b0, r_acc_q[13:0], 32'b0};
                div_req.divisor  = r_edges;
            end
            default: ;
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (edge_we)
            m_edge[edge_wa] <= edge_wd;
        r_edge_q <= m_edge[edge_ra];
    end

    always_ff @(posedge i_clk) begin
        if (odeg_we)
            m_odeg[odeg_wa] <= odeg_wd;
        r_odeg_q <= m_odeg[odeg_ra];
    end

    always_ff @(posedge i_clk) begin
        if (rank_we)
            m_rank[rank_wa] <= rank_wd;
        r_rank_q <= m_rank[rank_ra];
    end

    always_ff @(posedge i_clk) begin
        if (share_we)
            m_share[share_wa] <= div_rsp.quot[31:0];
        r_share_q <= m_share[share_ra];
    end

    always_ff @(posedge i_clk) begin
        if (acc_we)
            m_acc[acc_wa] <= acc_wd;
        r_acc_q <= m_acc[acc_ra];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= CW'(1024);
            r_damping    <= 16'd55706;
            r_tol        <= 32'd4295;
            r_maxit      <= 16'd1000;
            r_mode       <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                spr_pkg::REG_NODES: r_node_count <= i_cfg_data[CW-1:0];
                spr_pkg::REG_DAMP:  r_damping    <= i_cfg_data[15:0];
                spr_pkg::REG_TOL:   r_tol        <= i_cfg_data;
                spr_pkg::REG_MAXIT: r_maxit      <= i_cfg_data[15:0];
                spr_pkg::REG_MODE:  r_mode       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_idx       <= '0;
            r_clr_op    <= 1'b0;
            r_edges     <= '0;
            r_run_iter  <= '0;
            r_run_diff  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_out.ready)
                r_out_valid <= 1'b0;
            unique case (r_state)
                // zero the out-degree table
                S_CLR: begin
                    r_idx <= r_idx + EW'(1);
                    if (r_idx == EW'(NN - 1)) begin
                        r_idx        <= '0;
                        r_res_status <= spr_pkg::ST_OK;
                        r_res_rank   <= '0;
                        r_state      <= r_clr_op ? S_DONE : S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_res_status <= spr_pkg::ST_OK;
                    r_res_rank   <= '0;
                    r_src        <= i_in.edge_source;
                    r_idx        <= '0;
                    if (in_acc) begin
                        unique case (i_in.op)
                            spr_pkg::OP_LOAD: begin
                                if (reject) begin
                                    r_res_status <= spr_pkg::ST_REJECT;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_edges <= r_edges + EW'(1);
                                    r_state <= S_LD2;
                                end
                            end
                            spr_pkg::OP_RUN: begin
                                r_iter  <= '0;
                                r_state <= r_mode ? S_ID_ZERO : S_PR_DIV;
                            end
                            spr_pkg::OP_READ:
                                r_state <= ({1'b0, i_in.read_node} < n_eff) ? S_RD : S_DONE;
                            spr_pkg::OP_CLEAR: begin
                                r_edges  <= '0;
                                r_clr_op <= 1'b1;
                                r_state  <= S_CLR;
                            end
                            default: ;
                        endcase
                    end
                end
                S_LD2:   r_state <= S_DONE;
                S_RD: begin
                    r_res_rank <= r_rank_q;
                    r_state    <= S_DONE;
                end
                // start value and first vector
                S_PR_DIV: begin
                    if (div_rsp.done) begin
                        r_start <= spr_pkg::sat32(div_rsp.quot);
                        r_state <= S_PR_FILL;
                    end
                end
                S_PR_FILL: begin
                    r_idx <= r_idx + EW'(1);
                    if (last_node) begin
                        r_idx   <= '0;
                        r_dang  <= '0;
                        r_tk    <= '0;
                        r_state <= S_A_RD;
                    end
                end
                // node sweep: shares, dangling mass, teleport numerator
                S_A_RD:  r_state <= S_A_MUL;
                S_A_MUL: begin
                    r_cv    <= cv_full[47:16];
                    r_tkp   <= 49'(r_rank_q) * 49'(omd);
                    r_od    <= r_odeg_q;
                    r_state <= S_A_ACC;
                end
                S_A_ACC: begin
                    r_tk    <= r_tk + 59'(r_tkp);
                    r_state <= S_A_DIV;
                end
                S_A_DIV: begin
                    if (div_rsp.done) begin
                        if (r_od == 14'd0)
                            r_dang <= r_dang + 42'(div_rsp.quot[31:0]);
                        r_idx   <= r_idx + EW'(1);
                        r_state <= S_A_RD;
                        if (last_node) begin
                            r_idx   <= '0;
                            r_state <= S_B_RD;
                        end
                    end
                end
                // edge walk
                S_B_RD: begin
                    if (r_idx >= r_edges) begin
                        r_idx   <= '0;
                        r_state <= r_mode ? S_ID_RD : S_T_DIV;
                    end else begin
                        r_state <= S_B_E;
                    end
                end
                S_B_E: begin
                    r_t <= e_tgt;
                    if (e_in) begin
                        r_state <= S_B_ADD;
                    end else begin
                        r_idx   <= r_idx + EW'(1);
                        r_state <= S_B_RD;
                    end
                end
                S_B_ADD: begin
                    r_idx   <= r_idx + EW'(1);
                    r_state <= S_B_RD;
                end
                S_T_DIV: begin
                    if (div_rsp.done) begin
                        r_base  <= 44'(r_dang) + 44'(div_rsp.quot[42:0]);
                        r_diff  <= '0;
                        r_state <= S_C_RD;
                    end
                end
                // new vector and L1 difference
                S_C_RD:  r_state <= S_C_SUM;
                S_C_SUM: begin
                    r_nv    <= spr_pkg::sat32(nv_sum);
                    r_ov    <= r_rank_q;
                    r_state <= S_C_WR;
                end
                S_C_WR: begin
                    r_diff  <= r_diff + 43'(abs_d);
                    r_idx   <= r_idx + EW'(1);
                    r_state <= last_node ? S_C_END : S_C_RD;
                end
                S_C_END: begin
                    r_iter <= it_nx;
                    r_idx  <= '0;
                    if (more) begin
                        r_dang  <= '0;
                        r_tk    <= '0;
                        r_state <= S_A_RD;
                    end else begin
                        r_run_iter   <= it_nx;
                        r_run_diff   <= diff_sat;
                        r_res_status <= (diff_sat > r_tol) ? spr_pkg::ST_CAP : spr_pkg::ST_OK;
                        r_state      <= S_DONE;
                    end
                end
                // in-degree fraction
                S_ID_ZERO: begin
                    r_idx <= r_idx + EW'(1);
                    if (last_node) begin
                        r_idx   <= '0;
                        r_state <= S_B_RD;
                    end
                end
                S_ID_RD:   r_state <= S_ID_CALC;
                S_ID_CALC: begin
                    if (r_edges != '0) begin
                        r_state <= S_ID_DIV;
                    end else begin
                        r_idx   <= r_idx + EW'(1);
                        r_state <= S_ID_RD;
                        if (last_node) begin
                            r_run_iter <= '0;
                            r_run_diff <= '0;
                            r_state    <= S_DONE;
                        end
                    end
                end
                S_ID_DIV: begin
                    if (div_rsp.done) begin
                        r_idx   <= r_idx + EW'(1);
                        r_state <= S_ID_RD;
                        if (last_node) begin
                            r_run_iter <= '0;
                            r_run_diff <= '0;
                            r_state    <= S_DONE;
                        end
                    end
                end
                // hand the result to the output register
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_o_status  <= r_res_status;
                        r_o_rank    <= r_res_rank;
                        r_o_iter    <= r_run_iter;
                        r_o_diff    <= r_run_diff;
                        r_clr_op    <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready             = (r_state == S_IDLE);
    assign o_out.valid            = r_out_valid;
    assign o_out.status           = r_o_status;
    assign o_out.rank_value       = r_o_rank;
    assign o_out.iterations_done  = r_o_iter;
    assign o_out.final_difference = r_o_diff;
endmodule
`default_nettype wire

### rtl/spr_chk.sv
// ----------------------------------------------------------------------------
// spr_chk: port-level checks of the PageRank engine
// Watches the command and result channels; bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module spr_chk (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        i_in_ready,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [1:0]  i_status,
    input wire [31:0] i_rank,
    input wire [15:0] i_iter,
    input wire [31:0] i_diff
);
    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result item dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_status) && $stable(i_rank) && $stable(i_iter) && $stable(i_diff))
        else $error("result payload changed while stalled");

    // one item at a time: busy right after taking one
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second item taken while busy");

    // status code three never appears
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_status != 2'd3)
        else $error("undefined status code");

    // an unconverged run has done at least one step
    a_cap_iter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == 2'd2 |-> i_iter != 16'd0)
        else $error("cap status without iterations");
endmodule

bind sparse_pagerank_power_iteration spr_chk u_spr_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_status    (o_out.status),
    .i_rank      (o_out.rank_value),
    .i_iter      (o_out.iterations_done),
    .i_diff      (o_out.final_difference)
);
`default_nettype wire
